### rtl/crf_pkg.sv
// Shared types, codes and constants of the crossfader with linear ramp.
`default_nettype none

package crf_pkg;

    // Channel count and the index widths that follow from it
    localparam int NUM_CHANNELS = 16;
    localparam int CH_IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int CH_CMP_W = 9;
    localparam logic [CH_CMP_W-1:0] NUM_CH_V = CH_CMP_W'(NUM_CHANNELS);

    // Operation codes of an input request
    localparam logic [2:0] OP_TICK   = 3'd0;
    localparam logic [2:0] OP_MOVE   = 3'd1;
    localparam logic [2:0] OP_ASSIGN = 3'd2;
    localparam logic [2:0] OP_CLEAR  = 3'd3;
    localparam logic [2:0] OP_QUERY  = 3'd4;

    // Status codes of a result
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_CONFLICT = 2'd1;
    localparam logic [1:0] STAT_IGNORED  = 2'd2;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_FADE_TICKS      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAMES_PER_TICK = 2'd1;

    // Fixed point: Q1.30 inside, Q2.14 at the ports
    localparam int POS_W = 32;
    localparam logic [POS_W-1:0] ONE_Q30 = 32'h4000_0000;
    localparam logic [14:0] UNITY_Q14 = 15'd16384;
    localparam logic signed [15:0] TARGET_MIN = -16'sd16384;
    localparam logic signed [15:0] TARGET_MAX = 16'sd16384;

    // Serial divider
    localparam int DIV_W = 32;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    typedef struct packed {
        logic [2:0]         op;
        logic [3:0]         channel;
        logic               side;
        logic signed [15:0] target_pos;
    } t_in_item;

    typedef struct packed {
        logic [14:0]        gain;
        logic [1:0]         status;
        logic               fading;
        logic signed [15:0] position;
    } t_out_item;

    // Request class decided by the front end
    typedef enum logic [2:0] {
        K_NOP, K_TICK, K_MOVE, K_MOVE_BAD, K_ASSIGN, K_CLEAR, K_QUERY
    } t_kind;

    typedef struct packed {
        t_kind                  kind;
        logic [3:0]             channel;
        logic                   side;
        logic signed [POS_W-1:0] target;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_head;

    typedef struct packed {
        logic [15:0] fade_ticks;
        logic [15:0] frames_per_tick;
    } t_cfg;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } t_div_rsp;

endpackage

`default_nettype wire

### rtl/crf_front.sv
// Front end: takes requests, classifies them and queues them for the back end.
`default_nettype none

module crf_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  crf_pkg::t_in_item  i_item,
    output logic               o_full,
    output crf_pkg::t_cmd_head o_head,
    input  logic               i_take
);
    import crf_pkg::*;

    t_cmd       r_q [2];
    logic       r_wr, r_rd;
    logic [1:0] r_cnt;
    logic       n_wr, n_rd;
    logic [1:0] n_cnt;
    t_cmd       cls;
    logic       push_ok, pop_ok;

    // Classify the incoming request
    always_comb begin
        cls.channel = i_item.channel;
        cls.side    = i_item.side;
        cls.target  = {i_item.target_pos, 16'h0000};
        case (i_item.op)
            OP_TICK: begin
                cls.kind = K_TICK;
            end
            OP_MOVE: begin
                if (i_item.target_pos < TARGET_MIN || i_item.target_pos > TARGET_MAX) begin
                    cls.kind = K_MOVE_BAD;
                end else begin
                    cls.kind = K_MOVE;
                end
            end
            OP_ASSIGN: begin
                cls.kind = K_ASSIGN;
            end
            OP_CLEAR: begin
                cls.kind = K_CLEAR;
            end
            OP_QUERY: begin
                cls.kind = K_QUERY;
            end
            default: begin
                cls.kind = K_NOP;
            end
        endcase
    end

    // Two-entry request queue
    always_comb begin
        o_full      = (r_cnt == 2'd2);
        push_ok     = i_push && !o_full;
        pop_ok      = i_take && (r_cnt != 2'd0);
        n_wr        = push_ok ? ~r_wr : r_wr;
        n_rd        = pop_ok ? ~r_rd : r_rd;
        n_cnt       = r_cnt + {1'b0, push_ok} - {1'b0, pop_ok};
        o_head.valid = (r_cnt != 2'd0);
        o_head.cmd   = r_q[r_rd];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_q[r_wr] <= cls;
        end
    end

endmodule

`default_nettype wire

### rtl/crf_divider.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none

module crf_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  crf_pkg::t_div_req i_req,
    output crf_pkg::t_div_rsp o_rsp
);
    import crf_pkg::*;

    logic                 r_busy, r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_W:0]       r_rem;
    logic [DIV_W-1:0]     r_quo, r_div;
    logic                 n_busy, n_done;
    logic [DIV_CNT_W-1:0] n_cnt;
    logic [DIV_W:0]       trial, n_rem;
    logic                 fits;

    // One shift-subtract step
    always_comb begin
        trial = {r_rem[DIV_W-1:0], r_quo[DIV_W-1]};
        fits  = (trial >= {1'b0, r_div});
        n_rem = fits ? (trial - {1'b0, r_div}) : trial;
    end

    // Step control
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
        end else if (r_busy) begin
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == DIV_CNT_W'(DIV_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[DIV_W-2:0], fits};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

`default_nettype wire

### rtl/crf_back.sv
// Back end: fader state, channel sides, ramp and the result queue.
`default_nettype none

module crf_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  crf_pkg::t_cfg       i_cfg,
    input  crf_pkg::t_cmd_head  i_head,
    output logic                o_take,
    output crf_pkg::t_div_req   o_div_req,
    input  crf_pkg::t_div_rsp   i_div_rsp,
    output logic                o_empty,
    input  logic                i_pop,
    output crf_pkg::t_out_item  o_out
);
    import crf_pkg::*;

    typedef enum logic [1:0] {
        ST_EXEC = 2'b01,
        ST_DIV  = 2'b10
    } t_state;

    t_state                   r_state, n_state;
    logic signed [POS_W-1:0]  r_cur, n_cur, r_dest, n_dest;
    logic [POS_W-1:0]         r_step, n_step;
    logic                     r_active, n_active, r_left, n_left;
    logic [NUM_CHANNELS-1:0]  r_lmem, n_lmem, r_rmem, n_rmem;

    t_out_item                r_rq [2];
    logic                     r_rq_wr, r_rq_rd;
    logic [1:0]               r_rq_cnt;
    logic                     rq_room, push, pop_ok;
    t_out_item                res;

    logic                     in_range;
    logic [CH_IDX_W-1:0]      idx;
    logic [POS_W-1:0]         mag, gain_q30;
    logic [14:0]              gain_val;
    logic signed [POS_W:0]    cur_x, dest_x, step_x, dn, up;
    logic signed [POS_W:0]    dist_x;
    logic [POS_W-1:0]         prod;
    t_cmd                     cmd;

    assign cmd = i_head.cmd;

    // Shared datapath terms
    always_comb begin
        in_range = (CH_CMP_W'(cmd.channel) < NUM_CH_V);
        idx      = CH_IDX_W'(cmd.channel);
        mag      = r_cur[POS_W-1] ? POS_W'(-r_cur) : POS_W'(r_cur);
        if (mag > ONE_Q30) begin
            mag = ONE_Q30;
        end
        gain_q30 = ONE_Q30 - mag;
        gain_val = gain_q30[30:16];
        cur_x    = {r_cur[POS_W-1], r_cur};
        dest_x   = {r_dest[POS_W-1], r_dest};
        step_x   = {1'b0, r_step};
        dn       = cur_x - step_x;
        up       = cur_x + step_x;
        dist_x   = (cmd.target > r_cur) ? ({cmd.target[POS_W-1], cmd.target} - cur_x)
                                        : (cur_x - {cmd.target[POS_W-1], cmd.target});
        prod     = POS_W'(i_cfg.fade_ticks * i_cfg.frames_per_tick);
        rq_room  = (r_rq_cnt != 2'd2);
    end

    // Request execution
    always_comb begin
        n_state   = r_state;
        n_cur     = r_cur;
        n_dest    = r_dest;
        n_step    = r_step;
        n_active  = r_active;
        n_left    = r_left;
        n_lmem    = r_lmem;
        n_rmem    = r_rmem;
        o_take    = 1'b0;
        push      = 1'b0;
        res.gain   = '0;
        res.status = STAT_OK;
        o_div_req.start    = 1'b0;
        o_div_req.dividend = dist_x[POS_W-1:0];
        o_div_req.divisor  = prod;
        case (r_state)
            ST_EXEC: begin
                if (i_head.valid && rq_room) begin
                    o_take = 1'b1;
                    push   = 1'b1;
                    case (cmd.kind)
                        K_TICK: begin
                            if (r_active) begin
                                if (r_step == '0) begin
                                    n_cur    = r_dest;
                                    n_active = 1'b0;
                                end else if (r_left) begin
                                    if (dn <= dest_x) begin
                                        n_cur    = r_dest;
                                        n_active = 1'b0;
                                    end else begin
                                        n_cur = dn[POS_W-1:0];
                                    end
                                end else begin
                                    if (up >= dest_x) begin
                                        n_cur    = r_dest;
                                        n_active = 1'b0;
                                    end else begin
                                        n_cur = up[POS_W-1:0];
                                    end
                                end
                            end
                        end
                        K_MOVE: begin
                            if (cmd.target == r_cur) begin
                                res.status = STAT_IGNORED;
                            end else begin
                                n_dest = cmd.target;
                                n_left = (cmd.target < r_cur);
                                if (prod == '0) begin
                                    n_step   = '0;
                                    n_active = 1'b1;
                                end else begin
                                    // result follows once the step is divided out
                                    push            = 1'b0;
                                    o_div_req.start = 1'b1;
                                    n_state         = ST_DIV;
                                end
                            end
                        end
                        K_MOVE_BAD: begin
                            res.status = STAT_IGNORED;
                        end
                        K_ASSIGN: begin
                            if (in_range) begin
                                if ((r_lmem[idx] && cmd.side) || (r_rmem[idx] && !cmd.side)) begin
                                    res.status = STAT_CONFLICT;
                                end else if (!cmd.side) begin
                                    n_lmem[idx] = 1'b1;
                                end else begin
                                    n_rmem[idx] = 1'b1;
                                end
                            end
                        end
                        K_CLEAR: begin
                            n_lmem = '0;
                            n_rmem = '0;
                        end
                        K_QUERY: begin
                            if (!in_range) begin
                                res.gain = UNITY_Q14;
                            end else if (r_lmem[idx]) begin
                                res.gain = (r_cur <= 0) ? UNITY_Q14 : gain_val;
                            end else if (r_rmem[idx]) begin
                                res.gain = (r_cur >= 0) ? UNITY_Q14 : gain_val;
                            end else begin
                                res.gain = UNITY_Q14;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_DIV: begin
                if (i_div_rsp.done) begin
                    // a nonzero divisor never leaves the ramp without a step
                    n_step   = (i_div_rsp.quotient == '0) ? POS_W'(1) : i_div_rsp.quotient;
                    n_active = 1'b1;
                    push     = 1'b1;
                    n_state  = ST_EXEC;
                end
            end
            default: begin
                n_state = ST_EXEC;
            end
        endcase
        res.fading   = n_active;
        res.position = n_cur[POS_W-1:16];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_EXEC;
            r_cur    <= '0;
            r_dest   <= '0;
            r_step   <= '0;
            r_active <= 1'b0;
            r_left   <= 1'b0;
            r_lmem   <= '0;
            r_rmem   <= '0;
        end else begin
            r_state  <= n_state;
            r_cur    <= n_cur;
            r_dest   <= n_dest;
            r_step   <= n_step;
            r_active <= n_active;
            r_left   <= n_left;
            r_lmem   <= n_lmem;
            r_rmem   <= n_rmem;
        end
    end

    // Two-entry result queue
    assign pop_ok  = i_pop && (r_rq_cnt != 2'd0);
    assign o_empty = (r_rq_cnt == 2'd0);
    assign o_out   = r_rq[r_rq_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rq_wr  <= 1'b0;
            r_rq_rd  <= 1'b0;
            r_rq_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_rq_wr <= ~r_rq_wr;
            end
            if (pop_ok) begin
                r_rq_rd <= ~r_rq_rd;
            end
            r_rq_cnt <= r_rq_cnt + {1'b0, push} - {1'b0, pop_ok};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_rq[r_rq_wr] <= res;
        end
    end

endmodule

`default_nettype wire

### rtl/crossfader_ramp_gain.sv
// Top level of the crossfader with linear ramp: config registers and wiring.
`default_nettype none

// Two-sided crossfader. Requests (tick, move, assign, clear, query) enter a
// two-deep request queue and each yields exactly one result in a two-deep
// result queue, in order. Tick, assign, clear and query are done in the
// execution stage; a move that starts a ramp with a nonzero fade_ticks *
// frames_per_tick waits for the 32-step serial divider that works out the
// per-tick increment, and no other request runs meanwhile.
// Position is kept in Q1.30 and shown in Q2.14 (floor); write the two
// configuration registers only while the block is idle.
module crossfader_ramp_gain (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_push,
    output logic                            o_full,
    input  crf_pkg::t_in_item               i_in,
    output logic                            o_empty,
    input  logic                            i_pop,
    output crf_pkg::t_out_item              o_out,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [crf_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [15:0]                     i_cfg_data
);
    import crf_pkg::*;

    t_cfg      r_cfg;
    t_cmd_head head;
    logic      take;
    t_div_req  div_req;
    t_div_rsp  div_rsp;

    // Configuration registers, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_FADE_TICKS: begin
                    r_cfg.fade_ticks <= i_cfg_data;
                end
                REG_FRAMES_PER_TICK: begin
                    r_cfg.frames_per_tick <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    crf_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_item  (i_in),
        .o_full  (o_full),
        .o_head  (head),
        .i_take  (take)
    );

    crf_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    crf_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_head    (head),
        .o_take    (take),
        .o_div_req (div_req),
        .i_div_rsp (div_rsp),
        .o_empty   (o_empty),
        .i_pop     (i_pop),
        .o_out     (o_out)
    );

endmodule

`default_nettype wire

### rtl/crf_checker.sv
// Port-level checks of the crossfader and the bind that attaches them.
`default_nettype none

module crf_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               o_empty,
    input  logic               i_pop,
    input  crf_pkg::t_out_item o_out
);
    import crf_pkg::*;

    // Reset leaves no result waiting
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> o_empty)
        else $error("result queue not empty after reset");

    // Status is one of the defined codes
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> (o_out.status == STAT_OK || o_out.status == STAT_CONFLICT ||
                      o_out.status == STAT_IGNORED))
        else $error("undefined status code");

    // Gain never exceeds unity, and only a plain query carries one
    a_gain_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_out.gain != 15'd0) |-> (o_out.gain <= UNITY_Q14 &&
                                               o_out.status == STAT_OK))
        else $error("gain out of range");

    // Position stays within full left to full right
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> (o_out.position >= TARGET_MIN && o_out.position <= TARGET_MAX))
        else $error("position out of range");

    // A waiting result holds until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=> (!o_empty && $stable(o_out)))
        else $error("waiting result changed");

endmodule

bind crossfader_ramp_gain crf_checker u_crf_checker (.*);

`default_nettype wire

### dv/crossfader_ramp_gain_tb.sv
// Self-checking testbench of crossfader_ramp_gain: directed rows, then randomized phases.
module crossfader_ramp_gain_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import crf_pkg::*;

    localparam int CYCLE_LIMIT     = 1_200_000;
    localparam int PHASES          = 10;
    localparam int ITEMS_PER_PHASE = 175;
    localparam int PRESSURE_PHASE  = 5;
    localparam int HOLD_CYCLES     = 300;
    localparam int DRAIN_TAIL      = 60;
    // first op code past the defined set; 5 to 7 do nothing
    localparam logic [2:0] OP_UNUSED_LO = 3'd5;

    // One line of the directed sequence: a register write or a request
    typedef struct packed {
        bit                   cfg_wr;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [15:0]          reg_val;
        t_in_item             req;
        bit                   typed;
        t_out_item            want;
    } t_step_row;

    typedef struct {
        bit        typed;
        t_out_item want;
    } t_typed_want;

    localparam int N_ROWS = 30;
    localparam t_step_row DIRECTED [N_ROWS] = '{
        // zero divisor at reset: query, move, then a tick jumps to the target
        '{0, '0, '0, '{OP_QUERY, 4'd0, 1'b0, 16'sd0}, 1, '{UNITY_Q14, STAT_OK, 1'b0, 16'sd0}},
        '{0, '0, '0, '{OP_MOVE, 4'd0, 1'b0, 16'sd16384}, 1, '{15'd0, STAT_OK, 1'b1, 16'sd0}},
        '{0, '0, '0, '{OP_TICK, 4'd0, 1'b0, 16'sd0}, 1, '{15'd0, STAT_OK, 1'b0, 16'sd16384}},
        // assignments, conflict, same-side re-assign
        '{0, '0, '0, '{OP_ASSIGN, 4'd0, 1'b0, 16'sd0}, 1, '{15'd0, STAT_OK, 1'b0, 16'sd16384}},
        '{0, '0, '0, '{OP_QUERY, 4'd0, 1'b0, 16'sd0}, 1, '{15'd0, STAT_OK, 1'b0, 16'sd16384}},
        '{0, '0, '0, '{OP_ASSIGN, 4'd0, 1'b1, 16'sd0}, 1,
            '{15'd0, STAT_CONFLICT, 1'b0, 16'sd16384}},
        '{0, '0, '0, '{OP_ASSIGN, 4'd0, 1'b0, 16'sd0}, 1, '{15'd0, STAT_OK, 1'b0, 16'sd16384}},
        '{0, '0, '0, '{OP_ASSIGN, 4'd15, 1'b1, 16'sd0}, 1, '{15'd0, STAT_OK, 1'b0, 16'sd16384}},
        '{0, '0, '0, '{OP_QUERY, 4'd15, 1'b0, 16'sd0}, 1,
            '{UNITY_Q14, STAT_OK, 1'b0, 16'sd16384}},
        // target equal to position, and targets out of range
        '{0, '0, '0, '{OP_MOVE, 4'd0, 1'b0, 16'sd16384}, 1,
            '{15'd0, STAT_IGNORED, 1'b0, 16'sd16384}},
        '{0, '0, '0, '{OP_MOVE, 4'd0, 1'b0, 16'sd16385}, 1,
            '{15'd0, STAT_IGNORED, 1'b0, 16'sd16384}},
        '{0, '0, '0, '{OP_MOVE, 4'd0, 1'b0, -16'sd32768}, 1,
            '{15'd0, STAT_IGNORED, 1'b0, 16'sd16384}},
        // unused op code
        '{0, '0, '0, '{OP_UNUSED_LO, 4'd15, 1'b1, -16'sd1}, 1,
            '{15'd0, STAT_OK, 1'b0, 16'sd16384}},
        // sweep to full left, then gains and clear
        '{0, '0, '0, '{OP_MOVE, 4'd0, 1'b0, -16'sd16384}, 1,
            '{15'd0, STAT_OK, 1'b1, 16'sd16384}},
        '{0, '0, '0, '{OP_TICK, 4'd0, 1'b0, 16'sd0}, 1, '{15'd0, STAT_OK, 1'b0, -16'sd16384}},
        '{0, '0, '0, '{OP_QUERY, 4'd15, 1'b0, 16'sd0}, 1,
            '{15'd0, STAT_OK, 1'b0, -16'sd16384}},
        '{0, '0, '0, '{OP_CLEAR, 4'd0, 1'b0, 16'sd0}, 1, '{15'd0, STAT_OK, 1'b0, -16'sd16384}},
        '{0, '0, '0, '{OP_QUERY, 4'd0, 1'b0, 16'sd0}, 1,
            '{UNITY_Q14, STAT_OK, 1'b0, -16'sd16384}},
        // divisor 3: four ticks, the last one would overshoot
        '{1, REG_FADE_TICKS, 16'd3, '0, 0, '0},
        '{1, REG_FRAMES_PER_TICK, 16'd1, '0, 0, '0},
        '{0, '0, '0, '{OP_MOVE, 4'd0, 1'b0, 16'sd16384}, 0, '0},
        '{0, '0, '0, '{OP_TICK, 4'd0, 1'b0, 16'sd0}, 0, '0},
        '{0, '0, '0, '{OP_TICK, 4'd0, 1'b0, 16'sd0}, 0, '0},
        '{0, '0, '0, '{OP_TICK, 4'd0, 1'b0, 16'sd0}, 0, '0},
        '{0, '0, '0, '{OP_TICK, 4'd0, 1'b0, 16'sd0}, 0, '0},
        // largest divisor: quotient rounds to zero, step becomes one LSB
        '{1, REG_FADE_TICKS, 16'hFFFF, '0, 0, '0},
        '{1, REG_FRAMES_PER_TICK, 16'hFFFF, '0, 0, '0},
        '{0, '0, '0, '{OP_MOVE, 4'd0, 1'b0, -16'sd16384}, 0, '0},
        '{0, '0, '0, '{OP_TICK, 4'd0, 1'b0, 16'sd0}, 0, '0},
        // new target while the ramp is running
        '{0, '0, '0, '{OP_MOVE, 4'd0, 1'b0, 16'sd0}, 0, '0}
    };

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_push;
    logic                 o_full;
    t_in_item             i_in;
    logic                 o_empty;
    logic                 i_pop;
    t_out_item            o_out;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [15:0]          i_cfg_data;

    // Mirror of the fader state and registers
    logic signed [31:0] fader_pos  = '0;
    logic signed [31:0] fader_dest = '0;
    logic [31:0]        ramp_step  = '0;
    bit                 ramping      = 0;
    bit                 heading_left = 0;
    bit [15:0]          on_left  = '0;
    bit [15:0]          on_right = '0;
    logic [15:0]        cfg_fade_ticks      = '0;
    logic [15:0]        cfg_frames_per_tick = '0;

    t_out_item   owed_results[$];
    t_typed_want typed_q[$];
    int          mismatches = 0;
    int          cycle_cnt  = 0;
    bit          steady     = 0;
    bit          hold_rx    = 0;

    crossfader_ramp_gain DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .o_full      (o_full),
        .i_in        (i_in),
        .o_empty     (o_empty),
        .i_pop       (i_pop),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Advance the fader mirror by one request and return its result
    function automatic t_out_item fader_respond(t_in_item rq);
        t_out_item          res;
        longint             cur;
        longint             dst;
        longint             t14;
        longint             t30;
        longint             nxt;
        longint             mag;
        longint unsigned    span;
        longint unsigned    div;
        res = '0;
        cur = longint'(fader_pos);
        dst = longint'(fader_dest);
        case (rq.op)
            OP_TICK: begin
                if (ramping) begin
                    if (ramp_step == 0) begin
                        cur = dst;
                        ramping = 0;
                    end else begin
                        nxt = heading_left ? cur - longint'(ramp_step)
                                           : cur + longint'(ramp_step);
                        // stop on the target instead of passing it
                        if (heading_left ? (nxt <= dst) : (nxt >= dst)) begin
                            cur = dst;
                            ramping = 0;
                        end else begin
                            cur = nxt;
                        end
                    end
                end
            end
            OP_MOVE: begin
                t14 = longint'($signed(rq.target_pos));
                t30 = t14 * 65536;
                if (t14 < longint'(TARGET_MIN) || t14 > longint'(TARGET_MAX) || t30 == cur) begin
                    res.status = STAT_IGNORED;
                end else begin
                    span = (t30 > cur) ? longint'(t30 - cur) : longint'(cur - t30);
                    div = longint'(cfg_fade_ticks) * longint'(cfg_frames_per_tick);
                    if (div == 0) begin
                        ramp_step = '0;
                    end else begin
                        ramp_step = 32'(span / div);
                        if (ramp_step == 0)
                            ramp_step = 32'd1;
                    end
                    fader_dest = 32'(t30);
                    heading_left = (t30 < cur);
                    ramping = 1;
                end
            end
            OP_ASSIGN: begin
                if ((on_left[rq.channel] && rq.side) || (on_right[rq.channel] && !rq.side))
                    res.status = STAT_CONFLICT;
                else if (rq.side)
                    on_right[rq.channel] = 1;
                else
                    on_left[rq.channel] = 1;
            end
            OP_CLEAR: begin
                on_left = '0;
                on_right = '0;
            end
            OP_QUERY: begin
                mag = (cur < 0) ? -cur : cur;
                if (mag > longint'(ONE_Q30))
                    mag = longint'(ONE_Q30);
                // attenuated only when the fader leans away from the channel's side
                if (on_left[rq.channel] && cur > 0)
                    res.gain = 15'((longint'(ONE_Q30) - mag) >>> 16);
                else if (on_right[rq.channel] && cur < 0)
                    res.gain = 15'((longint'(ONE_Q30) - mag) >>> 16);
                else
                    res.gain = UNITY_Q14;
            end
            default: ;
        endcase
        fader_pos = 32'(cur);
        res.fading = ramping;
        res.position = 16'(cur >>> 16);
        return res;
    endfunction

    // Mostly short gaps, a few long ones; none in steady stretches
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 15);
        return $urandom_range(30, 80);
    endfunction

    // Random request: ramps driven by ticks, with assigns and queries between
    function automatic t_in_item build_request();
        t_in_item rq;
        int       r;
        int       t;
        rq.channel = 4'($urandom);
        rq.side = 1'($urandom);
        rq.target_pos = 16'($urandom);
        r = $urandom_range(0, 99);
        if (r < 38)
            rq.op = OP_TICK;
        else if (r < 56)
            rq.op = OP_MOVE;
        else if (r < 70)
            rq.op = OP_ASSIGN;
        else if (r < 74)
            rq.op = OP_CLEAR;
        else if (r < 94)
            rq.op = OP_QUERY;
        else
            rq.op = OP_UNUSED_LO + 3'($urandom_range(0, 2));
        if (rq.op == OP_MOVE) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
                // raw 16-bit noise, about half of it out of range
            end else if (r < 16) begin
                t = $urandom_range(0, 2);
                rq.target_pos = (t == 0) ? TARGET_MIN : (t == 1) ? TARGET_MAX : 16'sd0;
            end else if (r < 26) begin
                rq.target_pos = 16'(fader_pos >>> 16);
            end else begin
                t = int'($urandom_range(0, 32768)) - 16384;
                rq.target_pos = 16'(t);
            end
        end
        return rq;
    endfunction

    // Offer one request and hold it until the block takes it
    task automatic push_request(input t_in_item rq, input bit typed, input t_out_item want);
        int gap;
        gap = idle_gap();
        typed_q.push_back('{typed, want});
        if (gap > 0) begin
            i_push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_push <= 1'b1;
        i_in <= rq;
        do @(posedge i_clk); while (o_full);
        @(negedge i_clk);
    endtask

    // Stop offering and wait until every result is back
    task automatic settle_idle();
        i_push <= 1'b0;
        while (owed_results.size() != 0)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // One register write; valid is dropped again before the next request
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // Track register writes and accepted requests, check every result
    always @(posedge i_clk) begin
        t_out_item   pred;
        t_out_item   want;
        t_typed_want tw;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_FADE_TICKS:      cfg_fade_ticks = i_cfg_data;
                    REG_FRAMES_PER_TICK: cfg_frames_per_tick = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_push && !o_full) begin
                pred = fader_respond(i_in);
                tw = typed_q.pop_front();
                owed_results.push_back(tw.typed ? tw.want : pred);
            end
            if (i_pop && !o_empty) begin
                if (owed_results.size() == 0) begin
                    $error("result popped with nothing outstanding");
                    mismatches++;
                end else begin
                    want = owed_results.pop_front();
                    if (o_out.gain !== want.gain) begin
                        $error("gain: expected %0d, got %0d", want.gain, o_out.gain);
                        mismatches++;
                    end
                    if (o_out.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, o_out.status);
                        mismatches++;
                    end
                    if (o_out.fading !== want.fading) begin
                        $error("fading: expected %0d, got %0d", want.fading, o_out.fading);
                        mismatches++;
                    end
                    if (o_out.position !== want.position) begin
                        $error("position: expected %0d, got %0d", want.position,
                               o_out.position);
                        mismatches++;
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("crossfader_ramp_gain_tb: FAIL");
            $finish;
        end
    end

    // Result side: random pops, plus one long hold to back the block up
    initial begin
        int gap;
        i_pop = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (hold_rx) begin
                i_pop <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_rx = 0;
            end
            gap = idle_gap();
            if (gap > 0) begin
                i_pop <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_pop <= 1'b1;
            do @(posedge i_clk); while (o_empty);
            @(negedge i_clk);
        end
    end

    // Request side: reset, directed rows, then randomized phases
    initial begin
        logic [15:0] ft;
        logic [15:0] fpt;
        i_rst_n = 1'b0;
        i_push = 1'b0;
        i_in = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED[i]) begin
            if (DIRECTED[i].cfg_wr) begin
                settle_idle();
                write_reg(DIRECTED[i].reg_idx, DIRECTED[i].reg_val);
            end else begin
                push_request(DIRECTED[i].req, DIRECTED[i].typed, DIRECTED[i].want);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            settle_idle();
            case (p)
                0:       begin ft = 16'd0;     fpt = 16'd0;     end
                1:       begin ft = 16'hFFFF;  fpt = 16'hFFFF;  end
                2:       begin ft = 16'd1;     fpt = 16'd1;     end
                3:       begin ft = 16'd0;     fpt = 16'hFFFF;  end
                4:       begin ft = 16'hFFFF;  fpt = 16'd0;     end
                9:       begin ft = 16'($urandom); fpt = 16'($urandom); end
                default: begin
                    ft = 16'($urandom_range(1, 8));
                    fpt = 16'($urandom_range(1, 4));
                end
            endcase
            write_reg(REG_FADE_TICKS, ft);
            write_reg(REG_FRAMES_PER_TICK, fpt);
            steady = (p == 2) || (p == PRESSURE_PHASE);
            if (p == PRESSURE_PHASE)
                hold_rx = 1;
            repeat (ITEMS_PER_PHASE)
                push_request(build_request(), 1'b0, '0);
        end

        settle_idle();
        repeat (DRAIN_TAIL) @(posedge i_clk);
        if (mismatches == 0)
            $display("crossfader_ramp_gain_tb: PASS");
        else
            $display("crossfader_ramp_gain_tb: FAIL");
        $finish;
    end

endmodule
